// ===== hw/rtl/ids_pkg.sv =====
// Shared constants and codes for the indexed deque store.
package ids_pkg;

  // Storage geometry.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

  // Stream payload widths.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 3;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_IDX   = 3'd4,
    REQ_DEL_IDX    = 3'd5,
    REQ_DEL_VALUE  = 3'd6
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

endpackage

// ===== hw/rtl/indexed_deque_store.sv =====
// Top level of the indexed deque store: request sequencer around a ring buffer RAM.
//
// Usage: requests arrive on the s_ stream, one result per request leaves on the m_ stream.
// The store holds up to DEPTH words as a ring buffer in a single-port RAM; the front sits
// at a head pointer, so pushes and pops at either end move no data. RAM addresses come
// from one shared wrap-around adder (head plus logical index), apart from a push at the
// front, which writes the slot just below the head; one comparator serves the value
// search, all under a small sequencer.
// Push, error results and the ignored request code 7 go from the execute step straight to
// the emit step; pop and read pass the take step first, where the RAM read data is valid.
// Delete at index also passes the take step, then moves each later entry one place toward
// the front with a RAM read and a RAM write. Delete by value scans every entry up to the
// match (all of them if none matches), a RAM read and a compare each, then shifts the rest.
// One request is in work at a time; s_tready is high only while the sequencer is idle and
// comes back as the result is loaded into the output register.
// A finished result waits in the output register while m_tready is low, and the sequencer
// holds until that register is free, so no result is lost under a stall.
// Reset (rst, synchronous) empties the store and clears the output valid; RAM contents
// are not cleared, since only slots below the count are ever read.
module indexed_deque_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ids_pkg::IN_DATA_W-1:0]      s_tdata,  // value_in[31:0], position[35:32]
  input  logic [ids_pkg::REQ_W-1:0]          s_tuser,  // req_type[2:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ids_pkg::OUT_DATA_W-1:0]     m_tdata,  // value_out[31:0], count[36:32]
  output logic [ids_pkg::STATUS_W-1:0]       m_tuser   // status[2:0]
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TAKE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_EMIT
  } state_t;

  state_t                        state;
  ids_pkg::req_t                 req;
  logic [ids_pkg::DATA_W-1:0]    val;
  logic [3:0]                    pos;
  logic [ids_pkg::PTR_W-1:0]     head;
  logic [ids_pkg::CNT_W-1:0]     occ;
  logic [ids_pkg::PTR_W-1:0]     k;
  logic [ids_pkg::DATA_W-1:0]    res_value;
  ids_pkg::status_t              res_status;
  logic [31:0]                   out_value;
  ids_pkg::status_t              out_status;
  logic [4:0]                    out_count;

  // RAM port and shared address unit.
  logic                          ram_we;
  logic [ids_pkg::PTR_W-1:0]     ram_addr;
  logic [ids_pkg::DATA_W-1:0]    ram_wdata;
  logic [ids_pkg::DATA_W-1:0]    ram_rdata;
  logic [ids_pkg::PTR_W-1:0]     off;
  logic [ids_pkg::PTR_W:0]       sum;
  logic [ids_pkg::PTR_W-1:0]     phys;
  logic [ids_pkg::PTR_W-1:0]     head_dec;
  logic [ids_pkg::PTR_W-1:0]     head_inc;

  // Decoded conditions.
  logic                          is_empty;
  logic                          is_full;
  logic                          out_of_range;
  logic                          more_after_k;
  logic [63:0]                   in_wide;
  logic [63:0]                   res_wide;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {3'b000, out_count, out_value};
  assign m_tuser  = out_status;

  assign in_wide  = 64'(s_tdata[31:0]);
  assign res_wide = 64'(res_value);

  assign is_empty     = (occ == '0);
  assign is_full      = (occ == ids_pkg::CNT_W'(ids_pkg::DEPTH));
  assign out_of_range = (ids_pkg::CMP_W'(pos) >= ids_pkg::CMP_W'(occ)) ||
                        (ids_pkg::CMP_W'(pos) >= ids_pkg::CMP_W'(ids_pkg::DEPTH));
  assign more_after_k = ((ids_pkg::CNT_W'(k) + ids_pkg::CNT_W'(1)) < occ);

  // Head pointer steps with wrap-around.
  assign head_dec = (head == '0) ? ids_pkg::PTR_W'(ids_pkg::DEPTH - 1)
                                 : head - ids_pkg::PTR_W'(1);
  assign head_inc = (head == ids_pkg::PTR_W'(ids_pkg::DEPTH - 1)) ? '0
                                 : head + ids_pkg::PTR_W'(1);

  // Shared address unit: physical slot of logical index off.
  assign sum  = {1'b0, head} + {1'b0, off};
  assign phys = (sum >= (ids_pkg::PTR_W + 1)'(ids_pkg::DEPTH))
              ? ids_pkg::PTR_W'(sum - (ids_pkg::PTR_W + 1)'(ids_pkg::DEPTH))
              : sum[ids_pkg::PTR_W-1:0];

  // Offset selection and RAM port control for each sequencer step.
  always_comb begin
    off       = '0;
    ram_we    = 1'b0;
    ram_wdata = val;
    ram_addr  = phys;
    case (state)
      S_EXEC: begin
        case (req)
          ids_pkg::REQ_PUSH_FRONT: begin
            ram_addr = head_dec;
            ram_we   = !is_full;
          end
          ids_pkg::REQ_PUSH_BACK: begin
            off    = ids_pkg::PTR_W'(occ);
            ram_we = !is_full;
          end
          ids_pkg::REQ_POP_BACK: begin
            off = ids_pkg::PTR_W'(occ - ids_pkg::CNT_W'(1));
          end
          ids_pkg::REQ_READ_IDX, ids_pkg::REQ_DEL_IDX: begin
            off = ids_pkg::PTR_W'(pos);
          end
          default: begin
            off = '0;
          end
        endcase
      end
      S_SCAN_RD: begin
        off = k;
      end
      S_SHIFT_RD: begin
        off = k + ids_pkg::PTR_W'(1);
      end
      S_SHIFT_WR: begin
        off       = k;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: begin
        off = '0;
      end
    endcase
  end

  ids_ram #(
    .WIDTH (ids_pkg::DATA_W),
    .DEPTH (ids_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Request sequencer, store pointers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one is loaded now.
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req   <= ids_pkg::req_t'(s_tuser);
            val   <= in_wide[ids_pkg::DATA_W-1:0];
            pos   <= s_tdata[35:32];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // The offset is zero for a value search, so the scan starts at the front.
          k <= off;
          case (req)
            ids_pkg::REQ_PUSH_FRONT, ids_pkg::REQ_PUSH_BACK: begin
              state <= S_EMIT;
              if (is_full) begin
                res_value  <= '0;
                res_status <= ids_pkg::ST_FULL;
              end else begin
                res_value  <= val;
                res_status <= ids_pkg::ST_OK;
                occ        <= occ + ids_pkg::CNT_W'(1);
                if (req == ids_pkg::REQ_PUSH_FRONT) begin
                  head <= head_dec;
                end
              end
            end
            ids_pkg::REQ_POP_FRONT, ids_pkg::REQ_POP_BACK: begin
              res_value <= '0;
              if (is_empty) begin
                res_status <= ids_pkg::ST_EMPTY;
                state      <= S_EMIT;
              end else begin
                res_status <= ids_pkg::ST_OK;
                state      <= S_TAKE;
              end
            end
            ids_pkg::REQ_READ_IDX, ids_pkg::REQ_DEL_IDX: begin
              res_value <= '0;
              if (is_empty) begin
                res_status <= ids_pkg::ST_EMPTY;
                state      <= S_EMIT;
              end else if (out_of_range) begin
                res_status <= ids_pkg::ST_RANGE;
                state      <= S_EMIT;
              end else begin
                res_status <= ids_pkg::ST_OK;
                state      <= S_TAKE;
              end
            end
            ids_pkg::REQ_DEL_VALUE: begin
              res_value <= '0;
              if (is_empty) begin
                res_status <= ids_pkg::ST_EMPTY;
                state      <= S_EMIT;
              end else begin
                res_status <= ids_pkg::ST_OK;
                state      <= S_SCAN_RD;
              end
            end
            default: begin
              res_value  <= '0;
              res_status <= ids_pkg::ST_OK;
              state      <= S_EMIT;
            end
          endcase
        end
        S_TAKE: begin
          // Read data for the addressed entry is now valid.
          res_value <= ram_rdata;
          case (req)
            ids_pkg::REQ_POP_FRONT: begin
              head  <= head_inc;
              occ   <= occ - ids_pkg::CNT_W'(1);
              state <= S_EMIT;
            end
            ids_pkg::REQ_POP_BACK: begin
              occ   <= occ - ids_pkg::CNT_W'(1);
              state <= S_EMIT;
            end
            ids_pkg::REQ_DEL_IDX: begin
              if (more_after_k) begin
                state <= S_SHIFT_RD;
              end else begin
                occ   <= occ - ids_pkg::CNT_W'(1);
                state <= S_EMIT;
              end
            end
            default: begin
              state <= S_EMIT;
            end
          endcase
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          // Compare one stored entry against the search value.
          if (ram_rdata == val) begin
            res_value <= ram_rdata;
            if (more_after_k) begin
              state <= S_SHIFT_RD;
            end else begin
              occ   <= occ - ids_pkg::CNT_W'(1);
              state <= S_EMIT;
            end
          end else if (more_after_k) begin
            k     <= k + ids_pkg::PTR_W'(1);
            state <= S_SCAN_RD;
          end else begin
            res_status <= ids_pkg::ST_NOTFOUND;
            state      <= S_EMIT;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          // Entry k + 1 is written to slot k now; close the gap further on.
          k <= k + ids_pkg::PTR_W'(1);
          if ((ids_pkg::CNT_W'(k) + ids_pkg::CNT_W'(2)) < occ) begin
            state <= S_SHIFT_RD;
          end else begin
            occ   <= occ - ids_pkg::CNT_W'(1);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hand the result over once the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_value  <= res_wide[31:0];
            out_status <= res_status;
            out_count  <= 5'(occ);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ids_ram.sv =====
// Generic single-port RAM with registered read data.
module ids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, otherwise register the addressed word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
